// ----- rtl/glyph_outline_point_decoder_defines.svh -----
// Assertion macros of the glyph outline point decoder, used by gopd_dpath.
// Expects signals named clk and rst_n in the module that uses them.
`ifndef GLYPH_OUTLINE_POINT_DECODER_DEFINES_SVH
`define GLYPH_OUTLINE_POINT_DECODER_DEFINES_SVH

// Checks a condition at every rising clock edge outside reset.
`define GOPD_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("gopd: invariant violated");

// Checks that an antecedent implies a consequent in the same cycle.
`define GOPD_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gopd: implication violated");

`endif

// ----- rtl/gopd_pkg.sv -----
// Package for the glyph outline point decoder: sizes, codes and structs.
// Used by the controller, the datapath and the top level.
`default_nettype none

package gopd_pkg;

    localparam int MAX_POINTS   = 1024;
    localparam int MAX_CONTOURS = 64;
    localparam int PT_IDX_W     = $clog2(MAX_POINTS);
    localparam int PT_CNT_W     = PT_IDX_W + 1;
    localparam int CT_IDX_W     = $clog2(MAX_CONTOURS);
    localparam int CT_CNT_W     = CT_IDX_W + 1;

    localparam logic [2:0] ST_POINT     = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_COMPOSITE = 3'd2;
    localparam logic [2:0] ST_BAD_ORDER = 3'd3;
    localparam logic [2:0] ST_TOO_MANY  = 3'd4;

    typedef enum logic [9:0] {
        PH_HEAD   = 10'b00_0000_0001,
        PH_ENDS   = 10'b00_0000_0010,
        PH_ILEN   = 10'b00_0000_0100,
        PH_INSTR  = 10'b00_0000_1000,
        PH_FLAGS  = 10'b00_0001_0000,
        PH_REPEAT = 10'b00_0010_0000,
        PH_X      = 10'b00_0100_0000,
        PH_Y      = 10'b00_1000_0000,
        PH_DRAIN  = 10'b01_0000_0000,
        PH_IDLE   = 10'b10_0000_0000
    } phase_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_RESTART,
        CMD_PARSE,
        CMD_REPEAT,
        CMD_FETCH,
        CMD_CHECK,
        CMD_EMIT_RD,
        CMD_EMIT_OUT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic error;
        logic go_repeat;
        logic go_fetch;
        logic rep_more;
        logic again;
        logic emit_go;
    } stat_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       glyph_start;
    } in_t;

    typedef struct packed {
        logic signed [31:0]   point_x;
        logic signed [31:0]   point_y;
        logic                 on_curve;
        logic                 contour_end;
        logic [PT_IDX_W-1:0]  point_index;
        logic [2:0]           status;
        logic                 last;
    } out_t;

endpackage

`default_nettype wire

// ----- rtl/gopd_ctrl.sv -----
// Controller of the glyph outline point decoder: sequences the datapath.
// Depends on gopd_pkg for the command and status types.
`default_nettype none

module gopd_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic            glyph_start,
    input  wire gopd_pkg::stat_t st,
    output gopd_pkg::cmd_t       cmd,
    output logic                 busy
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_RESTART  = 8'b0000_0010,
        S_PARSE    = 8'b0000_0100,
        S_REPEAT   = 8'b0000_1000,
        S_FETCH    = 8'b0001_0000,
        S_CHECK    = 8'b0010_0000,
        S_EMIT_RD  = 8'b0100_0000,
        S_EMIT_OUT = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = gopd_pkg::CMD_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = gopd_pkg::CMD_LOAD;
                    state_next = glyph_start ? S_RESTART : S_PARSE;
                end
            end
            S_RESTART:
            begin
                cmd.op     = gopd_pkg::CMD_RESTART;
                state_next = S_PARSE;
            end
            S_PARSE:
            begin
                cmd.op = gopd_pkg::CMD_PARSE;
                priority if (st.error)     state_next = S_IDLE;
                else if (st.go_repeat)     state_next = S_REPEAT;
                else if (st.go_fetch)      state_next = S_FETCH;
                else                       state_next = S_EMIT_RD;
            end
            S_REPEAT:
            begin
                cmd.op = gopd_pkg::CMD_REPEAT;
                priority if (st.rep_more)  state_next = S_REPEAT;
                else if (st.go_fetch)      state_next = S_FETCH;
                else                       state_next = S_EMIT_RD;
            end
            S_FETCH:
            begin
                cmd.op     = gopd_pkg::CMD_FETCH;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.op     = gopd_pkg::CMD_CHECK;
                state_next = st.again ? S_FETCH : S_EMIT_RD;
            end
            S_EMIT_RD:
            begin
                cmd.op     = gopd_pkg::CMD_EMIT_RD;
                state_next = st.emit_go ? S_EMIT_OUT : S_IDLE;
            end
            S_EMIT_OUT:
            begin
                cmd.op     = gopd_pkg::CMD_EMIT_OUT;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

// ----- rtl/gopd_dpath.sv -----
// Datapath of the glyph outline point decoder: parse registers and point stores.
// Depends on gopd_pkg and on glyph_outline_point_decoder_defines.svh.
`default_nettype none
`include "glyph_outline_point_decoder_defines.svh"

module gopd_dpath (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire gopd_pkg::cmd_t cmd,
    input  wire gopd_pkg::in_t  item,
    output gopd_pkg::stat_t     st,
    output gopd_pkg::out_t      result,
    output logic                strobe
);

    localparam int PW = gopd_pkg::PT_IDX_W;
    localparam int PC = gopd_pkg::PT_CNT_W;
    localparam int CW = gopd_pkg::CT_IDX_W;
    localparam int CC = gopd_pkg::CT_CNT_W;

    gopd_pkg::phase_t phase_reg, phase_next;
    logic [15:0]  bc_reg, bc_next;
    logic [15:0]  cc_reg, cc_next;
    logic [15:0]  prev_end_reg, prev_end_next;
    logic [31:0]  rx_reg, rx_next;
    logic [31:0]  ry_reg, ry_next;
    logic [PC-1:0] pc_reg, pc_next;
    logic [PC-1:0] pp_reg, pp_next;
    logic [PC-1:0] ep_reg, ep_next;
    logic [CC-1:0] cp_reg, cp_next;
    logic [7:0]   hold_reg, hold_next;
    logic [7:0]   rep_hold_reg, rep_hold_next;
    logic [7:0]   rep_left_reg, rep_left_next;
    logic [5:0]   cur_flag_reg, cur_flag_next;
    logic [7:0]   byte_reg, byte_next;
    gopd_pkg::out_t result_reg, result_next;
    logic         strobe_reg, strobe_next;
    logic [2:0]   err_code;

    logic [5:0]   flags_mem [gopd_pkg::MAX_POINTS];
    logic [31:0]  x_mem     [gopd_pkg::MAX_POINTS];
    logic [31:0]  y_mem     [gopd_pkg::MAX_POINTS];
    logic [15:0]  ce_mem    [gopd_pkg::MAX_CONTOURS];
    logic [5:0]   flags_rd;
    logic [31:0]  x_rd, y_rd;
    logic [15:0]  ce_rd;

    logic          flags_we, flags_re, x_we, y_we, ce_we, emit_re;
    logic [5:0]    flags_wdata;
    logic [PW-1:0] flags_raddr;
    logic [31:0]   xy_wdata;

    logic [15:0]  w16;
    logic         is_y, short_bit, same_bit, done_delta, ce_hit;
    logic [31:0]  delta, sum;

    assign w16       = {hold_reg, byte_reg};
    assign is_y      = (phase_reg == gopd_pkg::PH_Y);
    assign short_bit = is_y ? cur_flag_reg[2] : cur_flag_reg[1];
    assign same_bit  = is_y ? cur_flag_reg[5] : cur_flag_reg[4];
    assign ce_hit    = ({{(16-CC){1'b0}}, cp_reg} < cc_reg) &&
                       (ce_rd == {{(16-PC){1'b0}}, ep_reg});

    always_comb
    begin
        phase_next    = phase_reg;
        bc_next       = bc_reg;
        cc_next       = cc_reg;
        prev_end_next = prev_end_reg;
        rx_next       = rx_reg;
        ry_next       = ry_reg;
        pc_next       = pc_reg;
        pp_next       = pp_reg;
        ep_next       = ep_reg;
        cp_next       = cp_reg;
        hold_next     = hold_reg;
        rep_hold_next = rep_hold_reg;
        rep_left_next = rep_left_reg;
        cur_flag_next = cur_flag_reg;
        byte_next     = byte_reg;
        result_next   = result_reg;
        strobe_next   = 1'b0;
        err_code      = gopd_pkg::ST_POINT;
        st            = '0;
        flags_we      = 1'b0;
        flags_re      = 1'b0;
        flags_wdata   = byte_reg[5:0];
        flags_raddr   = pp_reg[PW-1:0];
        x_we          = 1'b0;
        y_we          = 1'b0;
        ce_we         = 1'b0;
        emit_re       = 1'b0;
        xy_wdata      = rx_reg;
        done_delta    = 1'b0;
        delta         = '0;
        sum           = '0;

        unique case (cmd.op)
            gopd_pkg::CMD_NONE:
            begin
            end
            gopd_pkg::CMD_LOAD:
            begin
                byte_next = item.data_byte;
            end
            gopd_pkg::CMD_RESTART:
            begin
                phase_next    = gopd_pkg::PH_HEAD;
                bc_next       = '0;
                cc_next       = '0;
                rx_next       = '0;
                ry_next       = '0;
                pc_next       = '0;
                pp_next       = '0;
                cp_next       = '0;
                ep_next       = '0;
                hold_next     = '0;
                rep_hold_next = '0;
            end
            gopd_pkg::CMD_PARSE:
            begin
                unique case (phase_reg)
                    gopd_pkg::PH_HEAD:
                    begin
                        if (bc_reg == 16'd0)
                        begin
                            hold_next = byte_reg;
                            bc_next   = 16'd1;
                        end
                        else
                        begin
                            if (bc_reg == 16'd1)
                            begin
                                cc_next = w16;
                                priority if (w16 == 16'd0)   err_code = gopd_pkg::ST_EMPTY;
                                else if (w16[15])            err_code = gopd_pkg::ST_COMPOSITE;
                                else if (w16 > 16'(gopd_pkg::MAX_CONTOURS))
                                    err_code = gopd_pkg::ST_TOO_MANY;
                                else                         err_code = gopd_pkg::ST_POINT;
                            end
                            if (bc_reg >= 16'd9)
                            begin
                                phase_next = gopd_pkg::PH_ENDS;
                                bc_next    = '0;
                                cp_next    = '0;
                            end
                            else
                            begin
                                bc_next = bc_reg + 16'd1;
                            end
                        end
                    end
                    gopd_pkg::PH_ENDS:
                    begin
                        if (!bc_reg[0])
                        begin
                            hold_next = byte_reg;
                            bc_next   = 16'd1;
                        end
                        else
                        begin
                            bc_next = '0;
                            priority if (cp_reg != '0 && w16 <= prev_end_reg)
                                err_code = gopd_pkg::ST_BAD_ORDER;
                            else if (w16 >= 16'(gopd_pkg::MAX_POINTS))
                                err_code = gopd_pkg::ST_TOO_MANY;
                            else
                            begin
                                ce_we         = 1'b1;
                                prev_end_next = w16;
                                cp_next       = cp_reg + CC'(1);
                                if ({{(16-CC){1'b0}}, cp_reg} + 16'd1 >= cc_reg)
                                begin
                                    pc_next    = PC'(w16[PW-1:0]) + PC'(1);
                                    phase_next = gopd_pkg::PH_ILEN;
                                end
                            end
                        end
                    end
                    gopd_pkg::PH_ILEN:
                    begin
                        if (bc_reg == 16'd0)
                        begin
                            hold_next = byte_reg;
                            bc_next   = 16'd1;
                        end
                        else
                        begin
                            bc_next    = w16;
                            pp_next    = '0;
                            phase_next = (w16 != 16'd0) ? gopd_pkg::PH_INSTR
                                                        : gopd_pkg::PH_FLAGS;
                        end
                    end
                    gopd_pkg::PH_INSTR:
                    begin
                        bc_next = bc_reg - 16'd1;
                        if (bc_reg == 16'd1)
                        begin
                            phase_next = gopd_pkg::PH_FLAGS;
                        end
                    end
                    gopd_pkg::PH_FLAGS:
                    begin
                        if (pp_reg < pc_reg)
                        begin
                            flags_we = 1'b1;
                            pp_next  = pp_reg + PC'(1);
                        end
                        if (byte_reg[3])
                        begin
                            rep_hold_next = byte_reg;
                            phase_next    = gopd_pkg::PH_REPEAT;
                        end
                        else if (pp_next >= pc_reg)
                        begin
                            phase_next = gopd_pkg::PH_X;
                            pp_next    = '0;
                            rx_next    = '0;
                            bc_next    = '0;
                            st.go_fetch = 1'b1;
                        end
                    end
                    gopd_pkg::PH_REPEAT:
                    begin
                        rep_left_next = byte_reg;
                        st.go_repeat  = 1'b1;
                    end
                    gopd_pkg::PH_X, gopd_pkg::PH_Y:
                    begin
                        if (short_bit)
                        begin
                            done_delta = 1'b1;
                            delta = same_bit ? {24'd0, byte_reg} : 32'd0 - {24'd0, byte_reg};
                        end
                        else if (!bc_reg[0])
                        begin
                            hold_next = byte_reg;
                            bc_next   = 16'd1;
                        end
                        else
                        begin
                            bc_next    = '0;
                            done_delta = 1'b1;
                            delta      = {{16{w16[15]}}, w16};
                        end
                        if (done_delta)
                        begin
                            sum      = (is_y ? ry_reg : rx_reg) + delta;
                            xy_wdata = sum;
                            if (is_y)
                            begin
                                ry_next = sum;
                                y_we    = 1'b1;
                            end
                            else
                            begin
                                rx_next = sum;
                                x_we    = 1'b1;
                            end
                            pp_next     = pp_reg + PC'(1);
                            st.go_fetch = 1'b1;
                        end
                    end
                    gopd_pkg::PH_DRAIN, gopd_pkg::PH_IDLE:
                    begin
                    end
                    default:
                    begin
                    end
                endcase
            end
            gopd_pkg::CMD_REPEAT:
            begin
                flags_wdata = rep_hold_reg[5:0];
                if (rep_left_reg != 8'd0 && pp_reg < pc_reg)
                begin
                    flags_we      = 1'b1;
                    pp_next       = pp_reg + PC'(1);
                    rep_left_next = rep_left_reg - 8'd1;
                    st.rep_more   = 1'b1;
                end
                else if (pp_reg >= pc_reg)
                begin
                    phase_next  = gopd_pkg::PH_X;
                    pp_next     = '0;
                    rx_next     = '0;
                    bc_next     = '0;
                    st.go_fetch = 1'b1;
                end
                else
                begin
                    phase_next = gopd_pkg::PH_FLAGS;
                end
            end
            gopd_pkg::CMD_FETCH:
            begin
                flags_re = 1'b1;
            end
            gopd_pkg::CMD_CHECK:
            begin
                // A point whose delta is absent repeats the previous coordinate.
                if (pp_reg >= pc_reg)
                begin
                    if (is_y)
                    begin
                        phase_next = gopd_pkg::PH_DRAIN;
                    end
                    else
                    begin
                        phase_next = gopd_pkg::PH_Y;
                        pp_next    = '0;
                        ry_next    = '0;
                        bc_next    = '0;
                        cp_next    = '0;
                        ep_next    = '0;
                        st.again   = 1'b1;
                    end
                end
                else if (is_y ? (flags_rd[5] && !flags_rd[2]) : (flags_rd[4] && !flags_rd[1]))
                begin
                    xy_wdata = is_y ? ry_reg : rx_reg;
                    y_we     = is_y;
                    x_we     = !is_y;
                    pp_next  = pp_reg + PC'(1);
                    st.again = 1'b1;
                end
                else
                begin
                    cur_flag_next = flags_rd;
                end
            end
            gopd_pkg::CMD_EMIT_RD:
            begin
                if ((phase_reg == gopd_pkg::PH_Y || phase_reg == gopd_pkg::PH_DRAIN) &&
                    ep_reg < pp_reg)
                begin
                    st.emit_go  = 1'b1;
                    flags_re    = 1'b1;
                    flags_raddr = ep_reg[PW-1:0];
                    emit_re     = 1'b1;
                end
            end
            gopd_pkg::CMD_EMIT_OUT:
            begin
                result_next.point_x     = x_rd;
                result_next.point_y     = y_rd;
                result_next.on_curve    = flags_rd[0];
                result_next.contour_end = ce_hit;
                result_next.point_index = ep_reg[PW-1:0];
                result_next.status      = gopd_pkg::ST_POINT;
                result_next.last        = (ep_reg + PC'(1) == pc_reg);
                strobe_next             = 1'b1;
                if (ce_hit)
                begin
                    cp_next = cp_reg + CC'(1);
                end
                ep_next = ep_reg + PC'(1);
                if (ep_reg + PC'(1) >= pc_reg)
                begin
                    phase_next = gopd_pkg::PH_IDLE;
                end
            end
            default:
            begin
            end
        endcase

        if (err_code != gopd_pkg::ST_POINT)
        begin
            st.error           = 1'b1;
            phase_next         = gopd_pkg::PH_IDLE;
            result_next        = '0;
            result_next.status = err_code;
            result_next.last   = 1'b1;
            strobe_next        = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (flags_we)
        begin
            flags_mem[pp_reg[PW-1:0]] <= flags_wdata;
        end
        if (flags_re)
        begin
            flags_rd <= flags_mem[flags_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (x_we)
        begin
            x_mem[pp_reg[PW-1:0]] <= xy_wdata;
        end
        if (emit_re)
        begin
            x_rd <= x_mem[ep_reg[PW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (y_we)
        begin
            y_mem[pp_reg[PW-1:0]] <= xy_wdata;
        end
        if (emit_re)
        begin
            y_rd <= y_mem[ep_reg[PW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce_we)
        begin
            ce_mem[cp_reg[CW-1:0]] <= w16;
        end
        if (emit_re)
        begin
            ce_rd <= ce_mem[cp_reg[CW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= gopd_pkg::PH_HEAD;
            bc_reg       <= '0;
            cc_reg       <= '0;
            prev_end_reg <= '0;
            rx_reg       <= '0;
            ry_reg       <= '0;
            pc_reg       <= '0;
            pp_reg       <= '0;
            ep_reg       <= '0;
            cp_reg       <= '0;
            hold_reg     <= '0;
            rep_hold_reg <= '0;
            rep_left_reg <= '0;
            cur_flag_reg <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            bc_reg       <= bc_next;
            cc_reg       <= cc_next;
            prev_end_reg <= prev_end_next;
            rx_reg       <= rx_next;
            ry_reg       <= ry_next;
            pc_reg       <= pc_next;
            pp_reg       <= pp_next;
            ep_reg       <= ep_next;
            cp_reg       <= cp_next;
            hold_reg     <= hold_next;
            rep_hold_reg <= rep_hold_next;
            rep_left_reg <= rep_left_next;
            cur_flag_reg <= cur_flag_next;
            strobe_reg   <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        result_reg <= result_next;
    end

    assign result = result_reg;
    assign strobe = strobe_reg;

    `GOPD_ASSERT_IMPLIES(a_strobe_src, strobe_reg,
        $past(cmd.op == gopd_pkg::CMD_EMIT_OUT || cmd.op == gopd_pkg::CMD_PARSE))
    `GOPD_ASSERT_IMPLIES(a_status_last, strobe_reg && result_reg.status != gopd_pkg::ST_POINT,
        result_reg.last)
    `GOPD_ASSERT_ALWAYS(a_pp_bound, pp_reg <= pc_reg)
    `GOPD_ASSERT_ALWAYS(a_ep_bound, ep_reg <= pp_reg)

endmodule

`default_nettype wire

// ----- rtl/glyph_outline_point_decoder.sv -----
// Top level of the glyph outline point decoder.
// Depends on gopd_pkg, gopd_ctrl and gopd_dpath.
//
// Usage: drive item (data_byte, glyph_start) and raise start; a byte transfer
// takes place at a rising edge where start is high and busy is low. Set
// glyph_start on the first byte of each glyph record.
// Each byte is worked on alone: it is taken, then parsed, then looked at for
// a point to send; a glyph_start byte adds a restart step before the parse.
// A completed delta, or the last flag, adds a flag store read and a check,
// and the same pair again for each following point without a delta and for
// the switch from x to y. A repeat count n adds a repeat step per flag write,
// up to n writes, plus a closing step; a point to send adds a step for the
// coordinate store reads. The point stores are single write, single read.
// A result appears on result for exactly one cycle with strobe high, in the
// cycle after the byte's work ends; the receiver cannot stall, so it must
// take every strobe. Point results carry status 0; empty, composite,
// misordered or oversized glyphs give one status result with last set.
// Reset returns to the header phase with counters cleared; stores hold
// undefined data until written and need no clearing.
`default_nettype none

module glyph_outline_point_decoder (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire gopd_pkg::in_t  item,
    output gopd_pkg::out_t      result,
    output logic                strobe
);

    gopd_pkg::cmd_t  cmd;
    gopd_pkg::stat_t st;

    gopd_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .glyph_start (item.glyph_start),
        .st          (st),
        .cmd         (cmd),
        .busy        (busy)
    );

    gopd_dpath u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .st     (st),
        .result (result),
        .strobe (strobe)
    );

endmodule

`default_nettype wire

// ----- sim/glyph_outline_point_decoder_tb.sv -----
// Testbench for glyph_outline_point_decoder: sends glyph records byte by byte
// and checks every point and status result against a built-in decoder model.
// Depends on gopd_pkg and the RTL of the decoder only.
`timescale 1ns / 1ps

module glyph_outline_point_decoder_tb;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    gopd_pkg::in_t  item;
    gopd_pkg::out_t result;
    logic strobe;

    glyph_outline_point_decoder u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .result (result),
        .strobe (strobe)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Decoder model state.
    logic [15:0] end_tab [gopd_pkg::MAX_CONTOURS];
    logic [5:0]  flag_tab [gopd_pkg::MAX_POINTS];
    logic [31:0] x_tab [gopd_pkg::MAX_POINTS];
    logic [31:0] y_tab [gopd_pkg::MAX_POINTS];
    gopd_pkg::phase_t phase;
    int unsigned byte_cnt, contours, run_x, run_y, pt_count, pt_ptr;
    int unsigned ct_ptr, hold_byte, rep_byte, emit_ptr;

    gopd_pkg::out_t expected_points [$];
    int   errors;
    int   burst_left;
    int   bytes_sent;
    int   glyphs_sent;
    int   points_seen;
    int   status_seen;

    function automatic void restart_glyph();
        phase = gopd_pkg::PH_HEAD;
        byte_cnt = 0; contours = 0; run_x = 0; run_y = 0;
        pt_count = 0; pt_ptr = 0; ct_ptr = 0;
        hold_byte = 0; rep_byte = 0; emit_ptr = 0;
    endfunction

    function automatic gopd_pkg::out_t status_result(logic [2:0] code);
        gopd_pkg::out_t r;
        r = '0;
        r.status = code;
        r.last = 1'b1;
        phase = gopd_pkg::PH_IDLE;
        return r;
    endfunction

    function automatic void settle_y();
        while (pt_ptr < pt_count && (flag_tab[pt_ptr] & 6'h24) == 6'h20)
        begin
            y_tab[pt_ptr] = run_y;
            pt_ptr++;
        end
        if (pt_ptr >= pt_count)
            phase = gopd_pkg::PH_DRAIN;
    endfunction

    function automatic void open_y();
        phase = gopd_pkg::PH_Y; pt_ptr = 0; run_y = 0; byte_cnt = 0;
        ct_ptr = 0; emit_ptr = 0;
        settle_y();
    endfunction

    function automatic void settle_x();
        while (pt_ptr < pt_count && (flag_tab[pt_ptr] & 6'h12) == 6'h10)
        begin
            x_tab[pt_ptr] = run_x;
            pt_ptr++;
        end
        if (pt_ptr >= pt_count)
            open_y();
    endfunction

    function automatic void open_x();
        phase = gopd_pkg::PH_X; pt_ptr = 0; run_x = 0; byte_cnt = 0;
        settle_x();
    endfunction

    // Returns 1 once the delta of the current point is complete.
    function automatic bit take_delta(logic [7:0] b, bit is_y, output logic [31:0] d);
        logic [5:0]  f;
        logic [15:0] w;
        f = flag_tab[pt_ptr];
        d = '0;
        if (is_y ? f[2] : f[1])
        begin
            d = (is_y ? f[5] : f[4]) ? {24'd0, b} : 32'd0 - {24'd0, b};
            return 1'b1;
        end
        if (byte_cnt[0] == 1'b0)
        begin
            hold_byte = b;
            byte_cnt = 1;
            return 1'b0;
        end
        byte_cnt = 0;
        w = {hold_byte[7:0], b};
        d = {{16{w[15]}}, w};
        return 1'b1;
    endfunction

    function automatic bit decode_byte(logic [7:0] b, logic gs, output gopd_pkg::out_t r);
        int unsigned w;
        logic [31:0] d;
        r = '0;
        if (gs)
            restart_glyph();
        case (phase)
            gopd_pkg::PH_HEAD:
            begin
                if (byte_cnt == 0)
                begin
                    hold_byte = b;
                    byte_cnt = 1;
                end
                else
                begin
                    if (byte_cnt == 1)
                    begin
                        w = {16'd0, hold_byte[7:0], b};
                        contours = w;
                        if (w == 0)
                        begin
                            r = status_result(gopd_pkg::ST_EMPTY);
                            return 1'b1;
                        end
                        if (w[15])
                        begin
                            r = status_result(gopd_pkg::ST_COMPOSITE);
                            return 1'b1;
                        end
                        if (w > gopd_pkg::MAX_CONTOURS)
                        begin
                            r = status_result(gopd_pkg::ST_TOO_MANY);
                            return 1'b1;
                        end
                    end
                    if (byte_cnt >= 9)
                    begin
                        phase = gopd_pkg::PH_ENDS; byte_cnt = 0; ct_ptr = 0;
                    end
                    else
                        byte_cnt++;
                end
            end
            gopd_pkg::PH_ENDS:
            begin
                if (byte_cnt[0] == 1'b0)
                begin
                    hold_byte = b;
                    byte_cnt = 1;
                end
                else
                begin
                    byte_cnt = 0;
                    w = {16'd0, hold_byte[7:0], b};
                    if (ct_ptr > 0 && w <= end_tab[ct_ptr - 1])
                    begin
                        r = status_result(gopd_pkg::ST_BAD_ORDER);
                        return 1'b1;
                    end
                    if (w >= gopd_pkg::MAX_POINTS || ct_ptr >= gopd_pkg::MAX_CONTOURS)
                    begin
                        r = status_result(gopd_pkg::ST_TOO_MANY);
                        return 1'b1;
                    end
                    end_tab[ct_ptr] = w[15:0];
                    ct_ptr++;
                    if (ct_ptr >= contours)
                    begin
                        pt_count = w + 1;
                        phase = gopd_pkg::PH_ILEN;
                    end
                end
            end
            gopd_pkg::PH_ILEN:
            begin
                if (byte_cnt == 0)
                begin
                    hold_byte = b;
                    byte_cnt = 1;
                end
                else
                begin
                    byte_cnt = {16'd0, hold_byte[7:0], b};
                    pt_ptr = 0;
                    phase = (byte_cnt != 0) ? gopd_pkg::PH_INSTR : gopd_pkg::PH_FLAGS;
                end
            end
            gopd_pkg::PH_INSTR:
            begin
                byte_cnt--;
                if (byte_cnt == 0)
                    phase = gopd_pkg::PH_FLAGS;
            end
            gopd_pkg::PH_FLAGS:
            begin
                if (pt_ptr < pt_count)
                begin
                    flag_tab[pt_ptr] = b[5:0];
                    pt_ptr++;
                end
                if (b[3])
                begin
                    rep_byte = b;
                    phase = gopd_pkg::PH_REPEAT;
                end
                else if (pt_ptr >= pt_count)
                    open_x();
            end
            gopd_pkg::PH_REPEAT:
            begin
                for (int k = 0; k < b && pt_ptr < pt_count; k++)
                begin
                    flag_tab[pt_ptr] = rep_byte[5:0];
                    pt_ptr++;
                end
                if (pt_ptr >= pt_count)
                    open_x();
                else
                    phase = gopd_pkg::PH_FLAGS;
            end
            gopd_pkg::PH_X:
            begin
                if (take_delta(b, 1'b0, d))
                begin
                    run_x += d;
                    x_tab[pt_ptr] = run_x;
                    pt_ptr++;
                    settle_x();
                end
            end
            gopd_pkg::PH_Y:
            begin
                if (take_delta(b, 1'b1, d))
                begin
                    run_y += d;
                    y_tab[pt_ptr] = run_y;
                    pt_ptr++;
                    settle_y();
                end
            end
            default:
            begin
            end
        endcase

        if ((phase == gopd_pkg::PH_Y || phase == gopd_pkg::PH_DRAIN) && emit_ptr < pt_ptr)
        begin
            if (ct_ptr < contours && ct_ptr < gopd_pkg::MAX_CONTOURS &&
                end_tab[ct_ptr] == emit_ptr)
            begin
                r.contour_end = 1'b1;
                ct_ptr++;
            end
            r.point_x = x_tab[emit_ptr];
            r.point_y = y_tab[emit_ptr];
            r.on_curve = flag_tab[emit_ptr][0];
            r.point_index = emit_ptr[gopd_pkg::PT_IDX_W-1:0];
            r.status = gopd_pkg::ST_POINT;
            r.last = (emit_ptr + 1 == pt_count);
            emit_ptr++;
            if (emit_ptr >= pt_count)
                phase = gopd_pkg::PH_IDLE;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // One byte transfer; the sender pauses between bursts of random length.
    task automatic send_byte(logic [7:0] b, logic gs);
        gopd_pkg::out_t r;
        item <= '{data_byte: b, glyph_start: gs};
        if (!start)
            start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        bytes_sent++;
        if (decode_byte(b, gs, r))
            expected_points.insert(expected_points.size(), r);
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
        end
        else
            burst_left--;
    endtask

    task automatic send_word(int unsigned w, logic gs);
        send_byte(w[15:8], gs);
        send_byte(w[7:0], 1'b0);
    endtask

    task automatic sender_idle();
        if (start)
            start <= 1'b0;
        @(posedge clk);
    endtask

    // Bytes that only flush decoded points; once the glyph is done they are ignored.
    task automatic send_filler(int n);
        repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic send_bbox();
        repeat (8) send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // Builds a well-formed record with random content; cut > 0 stops it early.
    task automatic send_glyph(int ncont, int npts, logic gs, int cut);
        gopd_pkg::in_t bytes [$];
        logic [5:0]  exp_flags [$];
        int          e;
        int          hi;
        int          n_instr;
        logic [7:0]  f;
        int          rep;
        logic [15:0] w;
        bytes.insert(bytes.size(), '{data_byte: ncont[15:8], glyph_start: gs});
        bytes.insert(bytes.size(), '{data_byte: ncont[7:0], glyph_start: 1'b0});
        repeat (8)
            bytes.insert(bytes.size(),
                         '{data_byte: 8'($urandom_range(0, 255)), glyph_start: 1'b0});
        e = -1;
        for (int k = 0; k < ncont; k++)
        begin
            hi = npts - ncont + k;
            e = (k == ncont - 1) ? npts - 1 : $urandom_range(e + 1, hi);
            bytes.insert(bytes.size(), '{data_byte: e[15:8], glyph_start: 1'b0});
            bytes.insert(bytes.size(), '{data_byte: e[7:0], glyph_start: 1'b0});
        end
        n_instr = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 300) : $urandom_range(0, 3);
        bytes.insert(bytes.size(), '{data_byte: n_instr[15:8], glyph_start: 1'b0});
        bytes.insert(bytes.size(), '{data_byte: n_instr[7:0], glyph_start: 1'b0});
        repeat (n_instr)
            bytes.insert(bytes.size(),
                         '{data_byte: 8'($urandom_range(0, 255)), glyph_start: 1'b0});
        while (exp_flags.size() < npts)
        begin
            f = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 3) != 0)
                f[3] = 1'b0;
            bytes.insert(bytes.size(), '{data_byte: f, glyph_start: 1'b0});
            rep = 0;
            if (f[3])
            begin
                rep = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 4);
                bytes.insert(bytes.size(), '{data_byte: rep[7:0], glyph_start: 1'b0});
            end
            for (int k = 0; k <= rep && exp_flags.size() < npts; k++)
                exp_flags.insert(exp_flags.size(), f[5:0]);
        end
        for (int axis = 0; axis < 2; axis++)
        begin
            foreach (exp_flags[p])
            begin
                if (axis == 0 ? exp_flags[p][1] : exp_flags[p][2])
                    bytes.insert(bytes.size(),
                                 '{data_byte: 8'($urandom_range(0, 255)), glyph_start: 1'b0});
                else if (!(axis == 0 ? exp_flags[p][4] : exp_flags[p][5]))
                begin
                    case ($urandom_range(0, 5))
                        0: w = 16'h7FFF;
                        1: w = 16'h8000;
                        default: w = 16'($urandom_range(0, 65535));
                    endcase
                    bytes.insert(bytes.size(), '{data_byte: w[15:8], glyph_start: 1'b0});
                    bytes.insert(bytes.size(), '{data_byte: w[7:0], glyph_start: 1'b0});
                end
            end
        end
        glyphs_sent++;
        foreach (bytes[i])
        begin
            if (cut > 0 && i >= cut)
                break;
            send_byte(bytes[i].data_byte, bytes[i].glyph_start);
        end
        if (cut == 0)
            send_filler(npts + $urandom_range(0, 2));
    endtask

    task automatic test_no_start_after_reset();
        send_glyph(2, 6, 1'b0, 0);
    endtask

    task automatic test_status_codes();
        send_word(16'h0000, 1'b1);
        send_word(16'hFFFE, 1'b1);
        send_word(16'h8000, 1'b1);
        send_word(gopd_pkg::MAX_CONTOURS + 1, 1'b1);
        // Second end index equal to the first one.
        send_word(16'h0002, 1'b1);
        send_bbox();
        send_word(16'h0005, 1'b0);
        send_word(16'h0005, 1'b0);
        // End index one past the point store.
        send_word(16'h0001, 1'b1);
        send_bbox();
        send_word(gopd_pkg::MAX_POINTS, 1'b0);
        // A decoder that has given up ignores bytes until the next glyph.
        send_filler(3);
    endtask

    task automatic test_delta_extremes();
        send_word(16'h0001, 1'b1);
        send_bbox();
        send_word(16'h0003, 1'b0);
        send_word(16'h0000, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h07, 1'b0);
        send_byte(8'h37, 1'b0);
        send_byte(8'h31, 1'b0);
        send_word(16'h7FFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_word(16'h8000, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_filler(4);
    endtask

    task automatic test_repeat_overrun();
        send_word(16'h0001, 1'b1);
        send_bbox();
        send_word(16'h0002, 1'b0);
        send_word(16'h0000, 1'b0);
        send_byte(8'h39, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_filler(4);
        // Repeat count that follows the very last flag.
        send_word(16'h0001, 1'b1);
        send_bbox();
        send_word(16'h0000, 1'b0);
        send_word(16'h0000, 1'b0);
        send_byte(8'h38, 1'b0);
        send_byte(8'h05, 1'b0);
        send_filler(2);
    endtask

    task automatic test_restart_drop();
        send_glyph(1, 12, 1'b1, 0);
        send_glyph(3, 20, 1'b1, 40);
        send_glyph(1, 3, 1'b1, 0);
    endtask

    task automatic test_largest_glyph();
        send_word(gopd_pkg::MAX_CONTOURS, 1'b1);
        send_bbox();
        for (int k = 0; k < gopd_pkg::MAX_CONTOURS; k++)
            send_word(k * 16 + 15, 1'b0);
        send_word(16'h0000, 1'b0);
        repeat (4)
        begin
            send_byte(8'h39, 1'b0);
            send_byte(8'hFF, 1'b0);
        end
        send_filler(gopd_pkg::MAX_POINTS + 1);
    endtask

    task automatic test_random_glyphs();
        int ncont;
        int npts;
        while (bytes_sent < 1650)
        begin
            case ($urandom_range(0, 9))
                0:
                    send_filler($urandom_range(1, 4));
                1:
                begin
                    // Random header, often an error status.
                    send_word($urandom_range(0, 65535), 1'b1);
                    send_filler($urandom_range(0, 12));
                end
                default:
                begin
                    npts = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 200)
                                                        : $urandom_range(1, 16);
                    ncont = $urandom_range(1, (npts < 5) ? npts : 5);
                    send_glyph(ncont, npts, 1'b1,
                               ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : 0);
                end
            endcase
        end
    endtask

    always @(posedge clk)
    begin
        gopd_pkg::out_t want;
        if (rst_n && strobe)
        begin
            if (expected_points.size() == 0)
            begin
                $error("unexpected result: status %0d index %0d", result.status,
                       result.point_index);
                errors++;
            end
            else
            begin
                want = expected_points.pop_front();
                if (result.status == gopd_pkg::ST_POINT)
                    points_seen++;
                else
                    status_seen++;
                if (result.point_x !== want.point_x)
                begin
                    $error("point_x: expected %0d, got %0d", want.point_x, result.point_x);
                    errors++;
                end
                if (result.point_y !== want.point_y)
                begin
                    $error("point_y: expected %0d, got %0d", want.point_y, result.point_y);
                    errors++;
                end
                if (result.on_curve !== want.on_curve)
                begin
                    $error("on_curve: expected %0d, got %0d", want.on_curve, result.on_curve);
                    errors++;
                end
                if (result.contour_end !== want.contour_end)
                begin
                    $error("contour_end: expected %0d, got %0d", want.contour_end,
                           result.contour_end);
                    errors++;
                end
                if (result.point_index !== want.point_index)
                begin
                    $error("point_index: expected %0d, got %0d", want.point_index,
                           result.point_index);
                    errors++;
                end
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, result.status);
                    errors++;
                end
                if (result.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, result.last);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #10ms;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        errors = 0; bytes_sent = 0; glyphs_sent = 0;
        points_seen = 0; status_seen = 0;
        burst_left = 0;
        restart_glyph();
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_no_start_after_reset();
        test_status_codes();
        test_delta_extremes();
        test_repeat_overrun();
        test_restart_drop();
        test_largest_glyph();
        test_random_glyphs();
        sender_idle();

        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (expected_points.size() != 0)
            errors++;

        $display("Covered %0d glyph records in %0d byte transfers.", glyphs_sent, bytes_sent);
        $display("Checked %0d points and %0d status results.", points_seen, status_seen);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
